/* design/border_region_yuv_averager_core_assert.svh */
// Assertion macros shared by the border-region averager modules.
// Needs nothing else; the assertion bodies drop out when SYNTHESIS is defined.
`ifndef BORDER_REGION_YUV_AVERAGER_CORE_ASSERT_SVH
`define BORDER_REGION_YUV_AVERAGER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked at each rising edge, switched off while reset is high.
`define BRYA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked at every rising edge, reset included.
`define BRYA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRYA_ASSERT(label, clk, rst, prop, msg)
`define BRYA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* design/brya_pkg.sv */
// Shared types and constants of the border-region YUV averager.
// Used by the register block, the controller, the datapath and the top level.
`default_nettype none

package brya_pkg;

  // Default largest frame dimension handed to the top-level parameter.
  localparam int MAX_DIMENSION_DEFAULT = 4096;

  // Field and bus widths fixed by the interface.
  localparam int CFG_W    = 13;
  localparam int PIX_W    = 8;
  localparam int LANES    = 3;
  localparam int TDATA_W  = LANES * PIX_W;
  localparam int SUM_W    = 32;
  localparam int APB_A_W  = 3;
  localparam int APB_D_W  = 32;

  // Register values after reset.
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  // Register index, taken from the word address.
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Divider sequence: one saturation check, then one quotient bit a step.
  localparam int STEPS  = PIX_W + 1;
  localparam int STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

  // Controller states.
  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_AREA,
    ST_SCALE,
    ST_RECIP,
    ST_LOAD,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic area_en;
    logic scale_en;
    logic recip_en;
    logic div_load;
    logic div_first;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_end;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

/* design/brya_regs.sv */
// Configuration registers of the border-region averager behind an APB-style port.
// Depends on brya_pkg for widths, reset values and register indexes.
`default_nettype none

module brya_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [brya_pkg::APB_A_W-1:0]  paddr,
  input  wire logic [brya_pkg::APB_D_W-1:0]  pwdata,
  output logic      [brya_pkg::APB_D_W-1:0]  prdata,
  output logic                               pready,
  output logic      [brya_pkg::CFG_W-1:0]    frame_width,
  output logic      [brya_pkg::CFG_W-1:0]    frame_height
);
  import brya_pkg::*;

  reg_idx_t reg_idx;
  logic     wr_en;

  // Registers sit at word addresses, so bit 2 picks the register.
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH:  frame_width  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: frame_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data is the addressed register, zero-extended.
  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = APB_D_W'(frame_width);
      REG_HEIGHT: prdata = APB_D_W'(frame_height);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/brya_ctrl.sv */
// Controller of the border-region averager: sequences accumulation, divisor set-up,
// the per-frame division and the result hand-off. Depends on brya_pkg.
`default_nettype none
`include "border_region_yuv_averager_core_assert.svh"

module brya_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire brya_pkg::sts_t sts,
  output brya_pkg::cmd_t      cmd
);
  import brya_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step_cnt;
  logic [STEP_W-1:0] step_cnt_next;

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ACCUM;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    s_tready      = 1'b0;
    unique case (state)
      ST_ACCUM: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid && sts.frame_end) begin
          state_next = ST_AREA;
        end
      end
      ST_AREA: begin
        cmd.area_en = 1'b1;
        state_next  = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale_en = 1'b1;
        state_next   = ST_RECIP;
      end
      ST_RECIP: begin
        cmd.recip_en = 1'b1;
        state_next   = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_load  = 1'b1;
        step_cnt_next = '0;
        state_next    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (step_cnt == '0);
        if (step_cnt == STEP_LAST) begin
          state_next = ST_DONE;
        end else begin
          step_cnt_next = step_cnt + STEP_W'(1);
        end
      end
      ST_DONE: begin
        // Wait until the output register is free for the new averages.
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  `BRYA_ASSERT(a_out_free, clk, rst, cmd.out_load |-> !sts.out_busy, "result overwrote a waiting word")
  `BRYA_ASSERT(a_stall_after_end, clk, rst, (cmd.accept && sts.frame_end) |=> !s_tready, "input not held off after frame end")
  `BRYA_ASSERT(a_divide_done, clk, rst, (state == ST_DIVIDE && step_cnt == STEP_LAST) |=> (state == ST_DONE), "divider did not finish after its last step")
  `BRYA_ASSERT(a_step_range, clk, rst, step_cnt <= STEP_LAST, "divider step count out of range")

endmodule

`default_nettype wire

/* design/brya_dp.sv */
// Datapath of the border-region averager: position counters, region test, three sums,
// divisor set-up by reciprocal multiply, a three-lane restoring divider and the output word.
// Depends on brya_pkg and on commands from brya_ctrl.
`default_nettype none
`include "border_region_yuv_averager_core_assert.svh"

module brya_dp #(
  parameter int MAX_DIMENSION = brya_pkg::MAX_DIMENSION_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire brya_pkg::cmd_t                cmd,
  output brya_pkg::sts_t                     sts,
  input  wire logic [brya_pkg::CFG_W-1:0]    frame_width,
  input  wire logic [brya_pkg::CFG_W-1:0]    frame_height,
  input  wire logic [brya_pkg::TDATA_W-1:0]  s_tdata,
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [brya_pkg::TDATA_W-1:0]  m_tdata
);
  import brya_pkg::*;

  // Widths that follow from the largest dimension.
  localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
  localparam int CNT_W   = $clog2(MAX_DIMENSION);
  localparam int CW      = DIM_W + 3;
  localparam int AREA_W  = 2 * DIM_W;
  localparam int N_W     = $clog2(longint'(13) * MAX_DIMENSION * MAX_DIMENSION + 1);
  localparam int K       = N_W + 5;
  localparam int RECIP_W = N_W + 1;
  localparam int PROD_W  = N_W + RECIP_W;
  localparam int DIV_W   = PROD_W - K;
  localparam int CMP_W   = (DIV_W + PIX_W > SUM_W) ? DIV_W + PIX_W : SUM_W;
  // Reciprocal of 25, rounded up; exact for every dividend below 2**N_W.
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << K) + 64'd24) / 64'd25);

  logic [DIM_W-1:0]  width_c;
  logic [DIM_W-1:0]  height_c;
  logic [CNT_W-1:0]  col;
  logic [CNT_W-1:0]  row;
  logic [CNT_W-1:0]  x;
  logic [CNT_W-1:0]  y;
  logic [CW-1:0]     x5;
  logic [CW-1:0]     y5;
  logic [CW-1:0]     w4;
  logic              central;
  logic              last_col;
  logic              last_row;
  logic              frame_start;
  logic [AREA_W-1:0] area;
  logic [N_W-1:0]    scaled;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  divisor;
  logic [CMP_W-1:0]  dsh;

  assign frame_start = s_tuser;

  // Dimensions out of range are pulled into 1..MAX_DIMENSION.
  always_comb begin
    if (frame_width == '0) begin
      width_c = DIM_W'(1);
    end else if (int'(frame_width) > MAX_DIMENSION) begin
      width_c = DIM_W'(MAX_DIMENSION);
    end else begin
      width_c = DIM_W'(frame_width);
    end
    if (frame_height == '0) begin
      height_c = DIM_W'(1);
    end else if (int'(frame_height) > MAX_DIMENSION) begin
      height_c = DIM_W'(MAX_DIMENSION);
    end else begin
      height_c = DIM_W'(frame_height);
    end
  end

  // Position of this pixel; a frame start puts it at the origin.
  assign x = frame_start ? '0 : col;
  assign y = frame_start ? '0 : row;

  // Central region: 5y >= h, 5x >= w and 5x <= 4w.
  assign x5       = CW'(x) + (CW'(x) << 2);
  assign y5       = CW'(y) + (CW'(y) << 2);
  assign w4       = CW'(width_c) << 2;
  assign central  = (y5 >= CW'(height_c)) && (x5 >= CW'(width_c)) && (x5 <= w4);
  assign last_col = DIM_W'(x) >= (width_c - DIM_W'(1));
  assign last_row = DIM_W'(y) >= (height_c - DIM_W'(1));

  assign sts.frame_end = last_col && last_row;
  assign sts.out_busy  = m_tvalid && !m_tready;

  // Column and row counters; the row follows the origin when a frame starts mid-line.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : y + CNT_W'(1);
      end else begin
        col <= x + CNT_W'(1);
        row <= y;
      end
    end
  end

  // Divisor floor(13*w*h/25): area, times 13 by shift and add, times the reciprocal.
  always_ff @(posedge clk) begin
    if (cmd.area_en) begin
      area <= AREA_W'(width_c) * AREA_W'(height_c);
    end
    if (cmd.scale_en) begin
      scaled <= N_W'(({4'b0, area} << 3) + ({4'b0, area} << 2) + {4'b0, area});
    end
    if (cmd.recip_en) begin
      prod <= PROD_W'(scaled) * PROD_W'(RECIP);
    end
  end

  assign divisor = prod[PROD_W-1 -: DIV_W];

  // Shifted divisor: starts at divisor*256 for the saturation check, then halves.
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dsh <= CMP_W'({divisor, {PIX_W{1'b0}}});
    end else if (cmd.div_step) begin
      dsh <= dsh >> 1;
    end
  end

  // One lane for each of luma, V and U.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [PIX_W-1:0] pix;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] rem;
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] rem_diff;
    logic             ge;
    logic [PIX_W-1:0] quo;
    logic             sat;
    logic [PIX_W-1:0] avg;

    assign pix      = s_tdata[l*PIX_W +: PIX_W];
    assign sum_next = (frame_start ? '0 : sum) + (central ? '0 : SUM_W'(pix));
    assign rem_ext  = CMP_W'(rem);
    assign rem_diff = rem_ext - dsh;
    assign ge       = rem_ext >= dsh;

    // Border sum, cleared once its frame is handed to the divider.
    always_ff @(posedge clk) begin
      if (rst) begin
        sum <= '0;
      end else if (cmd.accept) begin
        sum <= sts.frame_end ? '0 : sum_next;
      end
    end

    // Restoring divider: the first step flags a quotient of 256 or more.
    always_ff @(posedge clk) begin
      if (cmd.accept && sts.frame_end) begin
        rem <= sum_next;
      end else if (cmd.div_step) begin
        if (cmd.div_first) begin
          sat <= ge;
          quo <= '0;
        end else begin
          quo <= {quo[PIX_W-2:0], ge};
          if (ge) begin
            rem <= SUM_W'(rem_diff);
          end
        end
      end
    end

    // Saturated average into the output word.
    always_ff @(posedge clk) begin
      if (cmd.out_load) begin
        avg <= sat ? {PIX_W{1'b1}} : quo;
      end
    end

    assign m_tdata[l*PIX_W +: PIX_W] = avg;
  end

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `BRYA_ASSERT_ALWAYS(a_no_word_after_reset, clk, rst |=> !m_tvalid, "output valid straight after reset")
  `BRYA_ASSERT(a_origin_after_frame, clk, rst, (cmd.accept && sts.frame_end) |=> (col == '0 && row == '0), "position not cleared after frame end")
  `BRYA_ASSERT(a_word_from_load, clk, rst, $rose(m_tvalid) |-> $past(cmd.out_load), "output valid without a result load")

endmodule

`default_nettype wire

/* design/border_region_yuv_averager_core.sv */
// Border-region YUV averager, top level. Pixels stream in on the s_ side at one word per
// clock, with the block counting column and row itself; the first pixel of a frame may be
// marked with tuser. At the last pixel of a frame the input is held off while the divisor
// floor(13*w*h/25) is formed (product, scale, reciprocal multiply, load) and a three-lane
// restoring divider produces one saturation check and eight quotient bits, and the averages
// are then loaded into the output word. If the previous word has not been taken, the hold
// lasts until it is. Between frames the block takes one pixel per clock, also while a
// result waits on the m_ side.
// Depends on brya_pkg, brya_regs, brya_ctrl and brya_dp.
`default_nettype none

module border_region_yuv_averager_core #(
  parameter int MAX_DIMENSION = brya_pkg::MAX_DIMENSION_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // APB-style configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [brya_pkg::APB_A_W-1:0]  paddr,
  input  wire logic [brya_pkg::APB_D_W-1:0]  pwdata,
  output logic      [brya_pkg::APB_D_W-1:0]  prdata,
  output logic                               pready,
  // Pixel input
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [brya_pkg::TDATA_W-1:0]  s_tdata,   // luma, chroma_v, chroma_u
  input  wire logic                          s_tuser,   // frame_start
  // Average output
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [brya_pkg::TDATA_W-1:0]  m_tdata    // average_y, average_v, average_u
);
  import brya_pkg::*;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  cmd_t             cmd;
  sts_t             sts;

  // Configuration registers.
  brya_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_width  (frame_width),
    .frame_height (frame_height)
  );

  // Sequencer.
  brya_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Counters, sums, divider and output word.
  brya_dp #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule

`default_nettype wire

/* tb/brya_average_checker.sv */
// Checker for the border-region YUV averager: watches the configuration, pixel and average
// channels, predicts each frame average and compares it with the word that the core emits.
// Depends on brya_pkg for widths, register indexes and reset values.
module brya_average_checker
  import brya_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_A_W-1:0] paddr,
  input  logic [APB_D_W-1:0] pwdata,
  input  logic               pready,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,    // luma, chroma_v, chroma_u
  input  logic               s_tuser,    // frame_start
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,    // average_y, average_v, average_u
  output int                 mismatches,
  output int                 pending,
  output int                 averages_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Packed so that the luma average sits in the lowest byte, as on the bus.
  typedef struct packed {
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] y;
  } averages_t;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned      column;
  int unsigned      row;
  logic [SUM_W-1:0] luma_total;
  logic [SUM_W-1:0] v_total;
  logic [SUM_W-1:0] u_total;
  averages_t        averages_due[$];

  // A zero dimension counts as one, anything above the maximum as the maximum.
  function automatic int unsigned dim_in_use(logic [CFG_W-1:0] d);
    if (d == '0) return 1;
    if (d > MAX_DIMENSION) return MAX_DIMENSION;
    return d;
  endfunction

  function automatic logic [PIX_W-1:0] border_mean(logic [SUM_W-1:0] total,
                                                   longint unsigned divisor);
    longint unsigned q;
    if (divisor == 0) return '1;
    q = total / divisor;
    return (q > 255) ? '1 : q[PIX_W-1:0];
  endfunction

  function automatic void restart_frame();
    column     = 0;
    row        = 0;
    luma_total = '0;
    v_total    = '0;
    u_total    = '0;
  endfunction

  // Adds one pixel to the border sums and, on the last pixel, queues the frame averages.
  function automatic void take_pixel(logic [TDATA_W-1:0] word, logic frame_start);
    longint unsigned w;
    longint unsigned h;
    longint unsigned divisor;
    averages_t       avg;
    bit              central;
    w = dim_in_use(width_reg);
    h = dim_in_use(height_reg);
    if (frame_start) restart_frame();
    central = (5 * row >= h) && (5 * column >= w) && (5 * column <= 4 * w);
    if (!central) begin
      luma_total += word[PIX_W-1:0];
      v_total    += word[2*PIX_W-1:PIX_W];
      u_total    += word[3*PIX_W-1:2*PIX_W];
    end
    if (column >= w - 1) begin
      if (row >= h - 1) begin
        divisor = (13 * w * h) / 25;
        avg.y = border_mean(luma_total, divisor);
        avg.v = border_mean(v_total, divisor);
        avg.u = border_mean(u_total, divisor);
        averages_due.push_back(avg);
        restart_frame();
      end else begin
        column = 0;
        row++;
      end
    end else begin
      column++;
    end
  endfunction

  function automatic void check_lane(string lane, logic [PIX_W-1:0] want,
                                     logic [PIX_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: average_%s expected %0d, got %0d", $time, lane, want, got);
    end
  endfunction

  // Everything is sampled at the rising edge; inputs only move at the falling edge.
  always @(posedge clk) begin
    averages_t want;
    averages_t got;
    if (rst) begin
      width_reg     = WIDTH_RESET;
      height_reg    = HEIGHT_RESET;
      mismatches    = 0;
      averages_seen = 0;
      averages_due.delete();
      restart_frame();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_WIDTH:  width_reg  = pwdata[CFG_W-1:0];
          REG_HEIGHT: height_reg = pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) take_pixel(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        got = averages_t'(m_tdata);
        averages_seen++;
        if (averages_due.size() == 0) begin
          mismatches++;
          $display("%0t: average word %h arrived with none expected", $time, m_tdata);
        end else begin
          want = averages_due.pop_front();
          check_lane("y", want.y, got.y);
          check_lane("v", want.v, got.v);
          check_lane("u", want.u, got.u);
        end
      end
    end
    pending = averages_due.size();
  end

endmodule

/* tb/tb.sv */
// Top of the border-region YUV averager testbench: clock, reset and stimulus for the core,
// with brya_average_checker alongside doing the prediction. Depends on brya_pkg.
module tb;
  import brya_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int SETTLE       = 30;
  localparam int RANDOM_WORDS = 410;

  typedef enum int {PIX_RANDOM, PIX_WHITE, PIX_BLACK, PIX_BRIGHT} pixel_style_e;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_A_W-1:0] paddr = '0;
  logic [APB_D_W-1:0] pwdata = '0;
  logic [APB_D_W-1:0] prdata;
  logic               pready;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               s_tuser = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  int                 mismatches;
  int                 pending;
  int                 averages_seen;

  int pixels_sent = 0;
  int sizes_tried = 0;
  int src_quiet   = 0;
  int sink_quiet  = 0;
  int sink_hold   = 0;

  border_region_yuv_averager_core DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  brya_average_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .mismatches    (mismatches),
    .pending       (pending),
    .averages_seen (averages_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle length: mostly none or short, a few long, and now and then a quiet stretch.
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 2) quiet = $urandom_range(20, 120);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Back-pressure on the average output.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_tready <= 1'b1;
      sink_hold = pick_gap(sink_quiet);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d averages outstanding", CYCLE_LIMIT, pending);
    $display("border_region_yuv_averager_core verification failed");
    $finish;
  end

  function automatic logic [PIX_W-1:0] sample(pixel_style_e style);
    case (style)
      PIX_WHITE:  return '1;
      PIX_BLACK:  return '0;
      PIX_BRIGHT: return PIX_W'($urandom_range(200, 255));
      default:    return PIX_W'($urandom);
    endcase
  endfunction

  // Offers one pixel word, after an optional gap, and waits until it is taken.
  task automatic send_pixel(logic [PIX_W-1:0] y, logic [PIX_W-1:0] v, logic [PIX_W-1:0] u,
                            logic start);
    int idle;
    idle = pick_gap(src_quiet);
    repeat (idle) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {u, v, y};
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  // Sends a run of pixels, with frame_start on the word at index mark_at (none if negative).
  task automatic send_frame(int count, int mark_at, pixel_style_e style);
    for (int i = 0; i < count; i++)
      send_pixel(sample(style), sample(style), sample(style), i == mark_at);
  endtask

  // Lets the core drain before the registers are touched.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {(APB_D_W - CFG_W)'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_frame_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    wait_idle();
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    sizes_tried++;
  endtask

  initial begin
    int           w;
    int           h;
    int           frame_pixels;
    int           r;
    int           directed_pixels;
    bit           realign;
    pixel_style_e style;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A few pixels at the reset size, then a shrink so the counters sit past the line end.
    send_pixel('0, '0, '0, 1'b1);
    send_pixel('1, '1, '1, 1'b0);
    send_pixel(8'h55, 8'haa, 8'h0f, 1'b0);
    set_frame_size(2, 2);
    send_frame(3, -1, PIX_RANDOM);
    // White 2x2 frame: the border sum exceeds 255 times the divisor.
    send_frame(4, 0, PIX_WHITE);
    // One-pixel frames: the divisor is zero.
    set_frame_size(1, 1);
    send_frame(1, 0, PIX_BRIGHT);
    send_frame(1, -1, PIX_RANDOM);
    set_frame_size(0, 0);
    send_frame(1, -1, PIX_BLACK);
    // A frame restarted part-way through by frame_start.
    set_frame_size(4, 4);
    send_frame(5, 0, PIX_RANDOM);
    send_frame(16, 0, PIX_RANDOM);
    // Start of the widest line and of the tallest column, the first through out-of-range
    // values; neither frame is finished, so the next frame is realigned by frame_start.
    set_frame_size(13'h1fff, 0);
    send_frame(30, 0, PIX_RANDOM);
    set_frame_size(0, 4096);
    send_frame(30, 0, PIX_BRIGHT);
    directed_pixels = pixels_sent;

    // Random small frames, mostly whole ones, with some cut short or restarted.
    realign = 1'b1;
    while (pixels_sent < directed_pixels + RANDOM_WORDS) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 8);
      h = ($urandom_range(9) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 8);
      set_frame_size(w, h);
      frame_pixels = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(9);
        style = (r < 3) ? pixel_style_e'(r + 1) : PIX_RANDOM;
        r = $urandom_range(99);
        if (r < 85) begin
          send_frame(frame_pixels, (realign || $urandom_range(1)) ? 0 : -1, style);
          realign = 1'b0;
        end else if (r < 93) begin
          send_frame($urandom_range(1, frame_pixels), 0, style);
          realign = 1'b1;
        end else begin
          send_frame(frame_pixels, $urandom_range(0, frame_pixels - 1), style);
          realign = 1'b1;
        end
      end
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d pixel words over %0d frame sizes, partial 4096-wide and 4096-tall frames included.",
             pixels_sent, sizes_tried);
    $display("Compared %0d frame averages; %0d mismatches.", averages_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("border_region_yuv_averager_core verification clean");
    end else begin
      $display("border_region_yuv_averager_core verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/brya_pkg.sv
design/brya_regs.sv
design/brya_ctrl.sv
design/brya_dp.sv
design/border_region_yuv_averager_core.sv
tb/brya_average_checker.sv
tb/tb.sv
